@@ hw/rtl/bfr_pkg.sv @@
// Shared constants, types and codes for the bitmap font text renderer.
package bfr_pkg;

   // Glyph geometry
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 8;
   localparam int GLYPH_COUNT  = 256;

   // Glyph store: one bank per glyph row slot, one byte per glyph in each bank
   localparam int ROW_SLOTS  = 8;
   localparam int ROW_BITS   = 8;
   localparam int GLYPH_BITS = ROW_SLOTS * ROW_BITS;
   localparam int GLYPH_AW   = $clog2(GLYPH_COUNT);
   localparam int SLOT_W     = $clog2(ROW_SLOTS);
   localparam int COL_W      = $clog2(ROW_BITS);

   // Field widths
   localparam int CELL_W   = 10;
   localparam int PIX_W    = 13;
   localparam int BPP_W    = 3;
   localparam int STRIDE_W = PIX_W + BPP_W;
   localparam int NG_W     = 9;
   localparam int DATA_W   = 32;
   localparam int CSR_IW   = 3;

   // Screen size in cells is capped at this many
   localparam int MAX_CELLS = 1024;

   // Work queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Control characters
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam int         TAB_STOP = 4;

   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_PUT  = 1'b1
   } req_kind_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_FRAME_BASE  = 3'd0,
      CSR_WIDTH_PX    = 3'd1,
      CSR_HEIGHT_PX   = 3'd2,
      CSR_BPP         = 3'd3,
      CSR_DEFAULT_FG  = 3'd4,
      CSR_DEFAULT_BG  = 3'd5,
      CSR_NUM_GLYPHS  = 3'd6
   } csr_index_type;

   // Configuration as seen by front and back
   typedef struct packed {
      logic [DATA_W-1:0]   frame_base;
      logic [PIX_W-1:0]    width_px;
      logic [PIX_W-1:0]    height_px;
      logic [BPP_W-1:0]    bpp;
      logic [DATA_W-1:0]   default_fg;
      logic [DATA_W-1:0]   default_bg;
      logic [NG_W-1:0]     num_glyphs;
      logic [STRIDE_W-1:0] stride;
   } cfg_type;

   // One character to draw: top-left pixel of the rightmost glyph column,
   // the glyph rows and the two colors
   typedef struct packed {
      logic [DATA_W-1:0]     addr;
      logic [GLYPH_BITS-1:0] glyph;
      logic [DATA_W-1:0]     fg;
      logic [DATA_W-1:0]     bg;
   } job_type;

endpackage

@@ hw/rtl/bitmap_font_text_renderer.sv @@
// Top level of the bitmap font text renderer: registers, front, queue, back.
//
// Usage:
//  - Request channel (req_push/req_full): a word is taken when req_push is
//    high and req_full low. A load word (req_type 0) stores one glyph row
//    byte; a put word (req_type 1) handles a character at the cursor or at
//    the given cell. Line feed, carriage return and tab only move the cursor.
//  - Result channel (rsp_empty/rsp_pop): one pixel write word per glyph bit,
//    64 per drawn character, column by column, rsp_last on the final one.
//  - Register channel (csr_valid/csr_ready): csr_ready is always high;
//    write registers only while no character is being drawn.
//  - Throughput is one pixel word per cycle while rsp_pop is kept high,
//    set by the single back-end pixel walker. Load and control words
//    emit nothing.
//  - The front runs ahead of the back through a four-entry job queue;
//    req_full rises once four drawing jobs are queued or in flight.
//  - When the receiver holds rsp_pop low, the result word holds, the back
//    end stops, the queue fills and then req_full stalls the sender.
//  - Reset clears the cursor, the registers to their defaults and all
//    queues. The glyph store is not cleared: load glyphs before use.
module bitmap_font_text_renderer (
   input  logic                               clock,
   input  logic                               reset,
   // request words
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_type,
   input  logic [7:0]                         req_char_code,
   input  logic [2:0]                         req_glyph_row,
   input  logic [7:0]                         req_glyph_bits,
   input  logic                               req_at_position,
   input  logic [bfr_pkg::CELL_W-1:0]         req_cell_col,
   input  logic [bfr_pkg::CELL_W-1:0]         req_cell_row,
   input  logic                               req_use_defaults,
   input  logic [bfr_pkg::DATA_W-1:0]         req_fg_color,
   input  logic [bfr_pkg::DATA_W-1:0]         req_bg_color,
   // pixel write words
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [bfr_pkg::DATA_W-1:0]         rsp_pixel_address,
   output logic [bfr_pkg::DATA_W-1:0]         rsp_pixel_value,
   output logic                               rsp_last,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfr_pkg::CSR_IW-1:0]         csr_index,
   input  logic [bfr_pkg::DATA_W-1:0]         csr_wdata
);
   import bfr_pkg::*;

   logic [DATA_W-1:0]   frame_base_ff;
   logic [PIX_W-1:0]    width_px_ff;
   logic [PIX_W-1:0]    height_px_ff;
   logic [BPP_W-1:0]    bpp_ff;
   logic [DATA_W-1:0]   default_fg_ff;
   logic [DATA_W-1:0]   default_bg_ff;
   logic [NG_W-1:0]     num_glyphs_ff;
   logic [STRIDE_W-1:0] stride_ff, stride_in;

   cfg_type             cfg;
   logic                csr_write;
   logic                q_push, q_pop, q_empty;
   job_type             q_job, q_head;
   logic [QUEUE_CW-1:0] q_count;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= '0;
         width_px_ff   <= PIX_W'(1024);
         height_px_ff  <= PIX_W'(768);
         bpp_ff        <= BPP_W'(4);
         default_fg_ff <= '1;
         default_bg_ff <= '0;
         num_glyphs_ff <= NG_W'(256);
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_BASE: frame_base_ff <= csr_wdata;
            CSR_WIDTH_PX:   width_px_ff   <= csr_wdata[PIX_W-1:0];
            CSR_HEIGHT_PX:  height_px_ff  <= csr_wdata[PIX_W-1:0];
            CSR_BPP:        bpp_ff        <= csr_wdata[BPP_W-1:0];
            CSR_DEFAULT_FG: default_fg_ff <= csr_wdata;
            CSR_DEFAULT_BG: default_bg_ff <= csr_wdata;
            CSR_NUM_GLYPHS: num_glyphs_ff <= csr_wdata[NG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Line stride in bytes, kept in a register off the pixel paths
   assign stride_in = STRIDE_W'(width_px_ff) * STRIDE_W'(bpp_ff);

   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
   end

   assign cfg.frame_base = frame_base_ff;
   assign cfg.width_px   = width_px_ff;
   assign cfg.height_px  = height_px_ff;
   assign cfg.bpp        = bpp_ff;
   assign cfg.default_fg = default_fg_ff;
   assign cfg.default_bg = default_bg_ff;
   assign cfg.num_glyphs = num_glyphs_ff;
   assign cfg.stride     = stride_ff;

   bfr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_type         (req_type),
      .req_char_code    (req_char_code),
      .req_glyph_row    (req_glyph_row),
      .req_glyph_bits   (req_glyph_bits),
      .req_at_position  (req_at_position),
      .req_cell_col     (req_cell_col),
      .req_cell_row     (req_cell_row),
      .req_use_defaults (req_use_defaults),
      .req_fg_color     (req_fg_color),
      .req_bg_color     (req_bg_color),
      .q_count          (q_count),
      .q_push           (q_push),
      .q_job            (q_job)
   );

   bfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head),
      .count    (q_count)
   );

   bfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last          (rsp_last)
   );

endmodule

@@ hw/rtl/bfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/bfr_front.sv @@
// Front end: takes request words, loads the glyph store, moves the cursor
// and prepares drawing jobs for the queue.
module bfr_front (
   input  logic                           clock,
   input  logic                           reset,
   input  bfr_pkg::cfg_type               cfg,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_type,
   input  logic [7:0]                     req_char_code,
   input  logic [2:0]                     req_glyph_row,
   input  logic [7:0]                     req_glyph_bits,
   input  logic                           req_at_position,
   input  logic [bfr_pkg::CELL_W-1:0]     req_cell_col,
   input  logic [bfr_pkg::CELL_W-1:0]     req_cell_row,
   input  logic                           req_use_defaults,
   input  logic [bfr_pkg::DATA_W-1:0]     req_fg_color,
   input  logic [bfr_pkg::DATA_W-1:0]     req_bg_color,
   input  logic [bfr_pkg::QUEUE_CW-1:0]   q_count,
   output logic                           q_push,
   output bfr_pkg::job_type               q_job
);
   import bfr_pkg::*;

   localparam int PY_W = PIX_W + STRIDE_W;
   localparam int PX_W = PIX_W + BPP_W;

   // Cursor
   logic [CELL_W-1:0] cursor_col_ff, cursor_col_in;
   logic [CELL_W-1:0] cursor_row_ff, cursor_row_in;

   // Stage 1: cell origin and colors, glyph read in flight
   logic              s1_valid_ff, s1_valid_in;
   logic [PIX_W-1:0]  s1_x0_ff, s1_x0_in;
   logic [PIX_W-1:0]  s1_y0_ff, s1_y0_in;
   logic [DATA_W-1:0] s1_fg_ff, s1_fg_in;
   logic [DATA_W-1:0] s1_bg_ff, s1_bg_in;

   // Stage 2: address products and glyph rows
   logic                  s2_valid_ff, s2_valid_in;
   logic [PY_W-1:0]       s2_prod_y_ff, s2_prod_y_in;
   logic [PX_W-1:0]       s2_prod_x_ff, s2_prod_x_in;
   logic [GLYPH_BITS-1:0] s2_glyph_ff, s2_glyph_in;
   logic [DATA_W-1:0]     s2_fg_ff, s2_fg_in;
   logic [DATA_W-1:0]     s2_bg_ff, s2_bg_in;

   logic [PIX_W-1:0]      cols_q, rows_q;
   logic [CELL_W:0]       cols, rows;
   logic [CELL_W-1:0]     cx, cy;
   logic                  accept, is_put, is_ctrl, in_screen, move, draw, load;
   logic [CELL_W:0]       col_n, row_n;
   logic [GLYPH_AW-1:0]   glyph_sel;
   logic [GLYPH_BITS-1:0] ram_rows;
   logic [QUEUE_CW+1:0]   in_flight;

   // Screen size in cells
   assign cols_q = PIX_W'(cfg.width_px / GLYPH_WIDTH);
   assign rows_q = PIX_W'(cfg.height_px / GLYPH_HEIGHT);
   assign cols   = (cols_q > PIX_W'(MAX_CELLS)) ? (CELL_W+1)'(MAX_CELLS) : (CELL_W+1)'(cols_q);
   assign rows   = (rows_q > PIX_W'(MAX_CELLS)) ? (CELL_W+1)'(MAX_CELLS) : (CELL_W+1)'(rows_q);

   // Room for every job that may still reach the queue
   assign in_flight = (QUEUE_CW+2)'(q_count) + (QUEUE_CW+2)'(s1_valid_ff)
                    + (QUEUE_CW+2)'(s2_valid_ff);
   assign req_full  = in_flight >= (QUEUE_CW+2)'(QUEUE_DEPTH);

   // Classify the word
   assign accept    = req_push && !req_full;
   assign is_put    = req_type == REQ_PUT;
   assign is_ctrl   = (req_char_code == CHAR_LF) || (req_char_code == CHAR_CR)
                   || (req_char_code == CHAR_TAB);
   assign cx        = req_at_position ? req_cell_col : cursor_col_ff;
   assign cy        = req_at_position ? req_cell_row : cursor_row_ff;
   assign in_screen = ({1'b0, cx} < cols) && ({1'b0, cy} < rows);
   assign move      = accept && is_put && in_screen;
   assign draw      = move && !is_ctrl;
   assign load      = accept && !is_put && ({1'b0, req_char_code} < 9'(GLYPH_COUNT));

   // Codes past the loaded font fall back to glyph zero
   assign glyph_sel = (({1'b0, req_char_code} < cfg.num_glyphs)
                       && ({1'b0, req_char_code} < 9'(GLYPH_COUNT)))
                    ? GLYPH_AW'(req_char_code) : '0;

   // Next cursor position
   always_comb begin
      col_n = {1'b0, cx} + (CELL_W+1)'(1);
      row_n = {1'b0, cy};
      unique case (req_char_code)
         CHAR_LF: begin
            col_n = '0;
            row_n = {1'b0, cursor_row_ff} + (CELL_W+1)'(1);
         end
         CHAR_CR: begin
            col_n = '0;
            row_n = {1'b0, cursor_row_ff};
         end
         CHAR_TAB: begin
            col_n = ({1'b0, cursor_col_ff} + (CELL_W+1)'(TAB_STOP - 1))
                  & ~(CELL_W+1)'(TAB_STOP - 1);
            row_n = {1'b0, cursor_row_ff};
         end
         default: begin
         end
      endcase
      if (col_n >= cols) begin
         col_n = '0;
         row_n = row_n + (CELL_W+1)'(1);
      end
      if (row_n >= rows) begin
         row_n = '0;
      end
   end

   assign cursor_col_in = move ? col_n[CELL_W-1:0] : cursor_col_ff;
   assign cursor_row_in = move ? row_n[CELL_W-1:0] : cursor_row_ff;

   // Glyph store, one bank per row slot
   for (genvar r = 0; r < ROW_SLOTS; r++) begin : g_bank
      bfr_ram #(
         .WIDTH (ROW_BITS),
         .DEPTH (GLYPH_COUNT)
      ) u_bank (
         .clock   (clock),
         .wr_en   (load && (req_glyph_row == SLOT_W'(r))),
         .wr_addr (GLYPH_AW'(req_char_code)),
         .wr_data (req_glyph_bits),
         .rd_en   (draw),
         .rd_addr (glyph_sel),
         .rd_data (ram_rows[r*ROW_BITS +: ROW_BITS])
      );
   end

   // Stage 1 inputs
   assign s1_valid_in = draw;
   assign s1_x0_in    = PIX_W'(cx) * PIX_W'(GLYPH_WIDTH) + PIX_W'(GLYPH_WIDTH - 1);
   assign s1_y0_in    = PIX_W'(cy) * PIX_W'(GLYPH_HEIGHT);
   assign s1_fg_in    = req_use_defaults ? cfg.default_fg : req_fg_color;
   assign s1_bg_in    = req_use_defaults ? cfg.default_bg : req_bg_color;

   // Stage 2 inputs: row and column offsets
   assign s2_valid_in  = s1_valid_ff;
   assign s2_prod_y_in = PY_W'(s1_y0_ff) * PY_W'(cfg.stride);
   assign s2_prod_x_in = PX_W'(s1_x0_ff) * PX_W'(cfg.bpp);
   assign s2_glyph_in  = ram_rows;
   assign s2_fg_in     = s1_fg_ff;
   assign s2_bg_in     = s1_bg_ff;

   // Job out to the queue
   assign q_push      = s2_valid_ff;
   assign q_job.addr  = cfg.frame_base + DATA_W'(s2_prod_y_ff) + DATA_W'(s2_prod_x_ff);
   assign q_job.glyph = s2_glyph_ff;
   assign q_job.fg    = s2_fg_ff;
   assign q_job.bg    = s2_bg_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_x0_ff     <= s1_x0_in;
      s1_y0_ff     <= s1_y0_in;
      s1_fg_ff     <= s1_fg_in;
      s1_bg_ff     <= s1_bg_in;
      s2_prod_y_ff <= s2_prod_y_in;
      s2_prod_x_ff <= s2_prod_x_in;
      s2_glyph_ff  <= s2_glyph_in;
      s2_fg_ff     <= s2_fg_in;
      s2_bg_ff     <= s2_bg_in;
   end

endmodule

@@ hw/rtl/bfr_queue.sv @@
// Short job queue between front end and pixel back end.
module bfr_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  bfr_pkg::job_type             push_job,
   input  logic                         pop,
   output logic                         empty,
   output bfr_pkg::job_type             head,
   output logic [bfr_pkg::QUEUE_CW-1:0] count
);
   import bfr_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   // Pointers wrap over the entries
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + QUEUE_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + QUEUE_AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign empty = count_ff == '0;
   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != QUEUE_CW'(QUEUE_DEPTH)))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue read while empty");

endmodule

@@ hw/rtl/bfr_back.sv @@
// Back end: walks one glyph column by column and emits a pixel write word
// per glyph bit into the result register.
module bfr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bfr_pkg::cfg_type           cfg,
   input  logic                       q_empty,
   input  bfr_pkg::job_type           q_head,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [bfr_pkg::DATA_W-1:0] rsp_pixel_address,
   output logic [bfr_pkg::DATA_W-1:0] rsp_pixel_value,
   output logic                       rsp_last
);
   import bfr_pkg::*;

   localparam logic [COL_W-1:0]  W_LAST = COL_W'(GLYPH_WIDTH - 1);
   localparam logic [SLOT_W-1:0] H_LAST = SLOT_W'(GLYPH_HEIGHT - 1);

   logic              busy_ff, busy_in;
   job_type           job_ff, job_in;
   logic [COL_W-1:0]  w_ff, w_in;
   logic [SLOT_W-1:0] h_ff, h_in;
   logic [DATA_W-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0] colbase_ff, colbase_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_addr_ff, out_addr_in;
   logic [DATA_W-1:0] out_value_ff, out_value_in;
   logic              out_last_ff, out_last_in;

   logic              emit, is_last, load;
   logic [DATA_W-1:0] next_col;

   assign emit     = busy_ff && (!out_valid_ff || rsp_pop);
   assign is_last  = (w_ff == W_LAST) && (h_ff == H_LAST);
   assign load     = !q_empty && (!busy_ff || (emit && is_last));
   assign q_pop    = load;
   assign next_col = colbase_ff - DATA_W'(cfg.bpp);

   // Walk: down the column by stride, then one pixel left to the next column
   always_comb begin
      busy_in    = busy_ff;
      job_in     = job_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      addr_in    = addr_ff;
      colbase_in = colbase_ff;
      if (load) begin
         busy_in    = 1'b1;
         job_in     = q_head;
         w_in       = '0;
         h_in       = '0;
         addr_in    = q_head.addr;
         colbase_in = q_head.addr;
      end else if (emit) begin
         if (is_last) begin
            busy_in = 1'b0;
         end
         if (h_ff == H_LAST) begin
            h_in       = '0;
            w_in       = w_ff + COL_W'(1);
            colbase_in = next_col;
            addr_in    = next_col;
         end else begin
            h_in    = h_ff + SLOT_W'(1);
            addr_in = addr_ff + DATA_W'(cfg.stride);
         end
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_addr_in  = addr_ff;
         out_value_in = job_ff.glyph[{h_ff, w_ff}] ? job_ff.fg : job_ff.bg;
         out_last_in  = is_last;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         w_ff         <= '0;
         h_ff         <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      addr_ff      <= addr_in;
      colbase_ff   <= colbase_in;
      out_addr_ff  <= out_addr_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_value   = out_value_ff;
   assign rsp_last          = out_last_ff;

   a_mid_glyph_busy: assert property (@(posedge clock) disable iff (reset)
      (emit && !is_last) |=> busy_ff)
      else $error("back end went idle inside a glyph");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      load |=> (busy_ff && (w_ff == '0) && (h_ff == '0)))
      else $error("new glyph did not start at its first pixel");

endmodule
